FILE: rtl/core/fcf_pkg.sv
// fcf_pkg: shared constants, word types and control structs for the fir filter unit
// no dependencies; imported by fcf_ctrl, fcf_datapath and fir_convolution_filter_unit
package fcf_pkg;

	localparam int MAX_TAPS    = 64;
	localparam int SAMPLE_BITS = 16;

	// fixed field widths
	localparam int CMD_W  = 2;
	localparam int IDX_W  = 6;
	localparam int LEN_W  = 7;

	// derived widths
	localparam int TAP_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CNT_W  = ($clog2(MAX_TAPS + 1) > LEN_W) ? $clog2(MAX_TAPS + 1) : LEN_W;
	localparam int PROD_W = 2 * SAMPLE_BITS;
	localparam int ACC_W  = PROD_W + TAP_W + 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WR_TAP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]              cmd;
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic [IDX_W-1:0]              tap_index;
		logic signed [SAMPLE_BITS-1:0] tap_value;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic                          clipped;
	} out_word_t;

	// controller to datapath
	typedef struct packed {
		logic             start;     // push sample, clear accumulator
		logic             wr_coef;
		logic             clr_hist;
		logic             issue;     // read one tap pair
		logic [CNT_W-1:0] k;
		logic             load_out;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pipe_busy;
		logic out_hold;
	} dp_stat_t;

endpackage

FILE: rtl/core/fcf_ctrl.sv
// fcf_ctrl: command decode, tap sequencer and kernel length register
// depends on fcf_pkg
module fcf_ctrl import fcf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [CMD_W-1:0] in_cmd,
	input  logic             cfg_wr_en,
	input  logic [LEN_W-1:0] cfg_wr_data,
	input  dp_stat_t         stat,
	output dp_cmd_t          ctl
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MAC   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]       state_q;
	logic [LEN_W-1:0] kernel_len_q;
	logic [CNT_W-1:0] taps_q;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] taps_now;
	logic             accept;
	logic             last_k;
	logic             finish;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// clamp length to the tap store depth
	assign taps_now = (CNT_W'(kernel_len_q) > CNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS)
	                                                            : CNT_W'(kernel_len_q);
	assign last_k   = (k_q == taps_q - 1'b1);
	assign finish   = (state_q == ST_DRAIN) && !stat.pipe_busy && !stat.out_hold;

	always_comb begin
		ctl          = '0;
		ctl.start    = accept && (in_cmd == CMD_FILTER);
		ctl.wr_coef  = accept && (in_cmd == CMD_WR_TAP);
		ctl.clr_hist = accept && (in_cmd == CMD_CLEAR);
		ctl.issue    = (state_q == ST_MAC);
		ctl.k        = k_q;
		ctl.load_out = finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_len_q <= LEN_W'(1);
		end else if (cfg_wr_en) begin
			kernel_len_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			taps_q  <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						taps_q  <= taps_now;
						k_q     <= '0;
						state_q <= (taps_now == '0) ? ST_DRAIN : ST_MAC;
					end
				end
				ST_MAC: begin
					k_q <= k_q + 1'b1;
					if (last_k) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (finish) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// tap counter never runs past the latched length
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MAC |-> k_q < taps_q)
		else $error("tap counter past kernel length");

	// last tap issue hands over to drain
	a_mac_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MAC && last_k |=> state_q == ST_DRAIN)
		else $error("sequencer missed the last tap");

endmodule

FILE: rtl/core/fcf_datapath.sv
// fcf_datapath: history and coefficient memories, mac pipeline, rounding and output register
// depends on fcf_pkg
module fcf_datapath import fcf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  in_data,
	input  dp_cmd_t   ctl,
	output dp_stat_t  stat,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_data
);

	localparam logic signed [ACC_W-1:0] RND_C = ACC_W'(1) << (SAMPLE_BITS - 2);
	localparam logic signed [ACC_W-1:0] Y_MAX = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);

	logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
	logic [MAX_TAPS-1:0]           hist_vld_q;
	logic [MAX_TAPS-1:0]           coef_vld_q;
	logic [TAP_W-1:0]              wpos_q;
	logic [TAP_W-1:0]              wpos_nxt;
	logic [TAP_W-1:0]              kk;
	logic [TAP_W-1:0]              hist_addr;
	logic [TAP_W-1:0]              coef_waddr;
	logic                          coef_in_range;

	logic signed [SAMPLE_BITS-1:0] hist_s1;
	logic signed [SAMPLE_BITS-1:0] coef_s1;
	logic                          hvld_s1;
	logic                          cvld_s1;
	logic                          rd_vld_s1;
	logic signed [SAMPLE_BITS-1:0] mul_a;
	logic signed [SAMPLE_BITS-1:0] mul_b;
	logic signed [PROD_W-1:0]      prod_s2;
	logic                          prod_vld_s2;
	logic signed [ACC_W-1:0]       acc_q;

	logic signed [ACC_W-1:0]       acc_rnd;
	logic signed [ACC_W-1:0]       y_full;
	out_word_t                     res;
	out_word_t                     out_data_q;
	logic                          out_valid_q;

	assign wpos_nxt      = (wpos_q == TAP_W'(MAX_TAPS - 1)) ? '0 : wpos_q + 1'b1;
	assign kk            = ctl.k[TAP_W-1:0];
	// newest sample minus k, modulo depth
	assign hist_addr     = (wpos_q >= kk) ? wpos_q - kk : wpos_q + TAP_W'(MAX_TAPS) - kk;
	assign coef_waddr    = TAP_W'(in_data.tap_index);
	assign coef_in_range = (int'(in_data.tap_index) < MAX_TAPS);

	// memories, no reset
	always_ff @(posedge clk) begin
		if (ctl.start) hist_mem[wpos_nxt] <= in_data.sample_in;
		if (ctl.wr_coef && coef_in_range) coef_mem[coef_waddr] <= in_data.tap_value;
		hist_s1 <= hist_mem[hist_addr];
		coef_s1 <= coef_mem[kk];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			coef_vld_q <= '0;
			wpos_q     <= '0;
		end else begin
			if (ctl.clr_hist) hist_vld_q <= '0;
			if (ctl.start) begin
				hist_vld_q[wpos_nxt] <= 1'b1;
				wpos_q               <= wpos_nxt;
			end
			if (ctl.wr_coef && coef_in_range) coef_vld_q[coef_waddr] <= 1'b1;
		end
	end

	// mac pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			prod_vld_s2 <= 1'b0;
			hvld_s1     <= 1'b0;
			cvld_s1     <= 1'b0;
		end else begin
			rd_vld_s1   <= ctl.issue;
			prod_vld_s2 <= rd_vld_s1;
			hvld_s1     <= hist_vld_q[hist_addr];
			cvld_s1     <= coef_vld_q[kk];
		end
	end

	assign mul_a = cvld_s1 ? coef_s1 : '0;
	assign mul_b = hvld_s1 ? hist_s1 : '0;

	always_ff @(posedge clk) begin
		prod_s2 <= mul_a * mul_b;
		if (ctl.start)        acc_q <= '0;
		else if (prod_vld_s2) acc_q <= acc_q + ACC_W'(prod_s2);
	end

	// round half up, shift, saturate
	assign acc_rnd = acc_q + RND_C;
	assign y_full  = acc_rnd >>> (SAMPLE_BITS - 1);

	always_comb begin
		res.clipped = 1'b0;
		res.sample_out = y_full[SAMPLE_BITS-1:0];
		if (y_full > Y_MAX) begin
			res.sample_out = Y_MAX[SAMPLE_BITS-1:0];
			res.clipped    = 1'b1;
		end else if (y_full < Y_MIN) begin
			res.sample_out = Y_MIN[SAMPLE_BITS-1:0];
			res.clipped    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) out_data_q <= res;
	end

	assign out_valid      = out_valid_q;
	assign out_data       = out_data_q;
	assign stat.pipe_busy = rd_vld_s1 || prod_vld_s2;
	assign stat.out_hold  = out_valid_q && out_stall;

	// never overwrite a word that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> !(out_valid_q && out_stall))
		else $error("output word overwritten while stalled");

	// result is only taken once the mac pipe is empty
	a_load_drained: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> !rd_vld_s1 && !prod_vld_s2)
		else $error("output loaded with products in flight");

endmodule

FILE: rtl/core/fir_convolution_filter_unit.sv
// fir_convolution_filter_unit: streaming fir filter, one shared multiply-accumulate per tap
// path: accept, ST_MAC issues one tap pair per tap (taps = kernel_len clamped, zero skips it),
// registered reads, registered product, accumulator, ST_DRAIN loads the output; a new word
// stalls until then, longer while the output word is held; tap writes and clears stay idle
// reset: async active low; history and taps read as zero, kernel_len 1, no word pending
// depends on fcf_pkg, fcf_ctrl, fcf_datapath
module fir_convolution_filter_unit import fcf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// input channel
	input  logic             in_valid,
	output logic             in_stall,
	input  in_word_t         in_data,
	// output channel
	output logic             out_valid,
	input  logic             out_stall,
	output out_word_t        out_data,
	// kernel length register
	input  logic             cfg_wr_en,
	input  logic [LEN_W-1:0] cfg_wr_data
);

	// command strobes from the sequencer, status back from the datapath
	dp_cmd_t  ctl;
	dp_stat_t stat;

	// sequencer: accepts a word only when idle, walks taps, waits for the pipe
	// to empty and for a free output register before finishing
	fcf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_cmd      (in_data.cmd),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.stat        (stat),
		.ctl         (ctl)
	);

	// datapath: history ring and tap store with per-entry valid bits,
	// registered reads, registered product, wide accumulator, round and clip
	fcf_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.ctl       (ctl),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
